// ===== design/fcte_pkg.sv =====
// ----------------------------------------------------------------------------
// fcte_pkg
// Shared constants of the cluster table engine: table size, widths, command
// codes, status codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package fcte_pkg;

  // table geometry
  localparam int unsigned TableEntries = 4096;
  localparam int unsigned AddrW        = $clog2(TableEntries);
  localparam int unsigned CountW       = 13;
  localparam int unsigned DataW        = 32;

  // first cluster that allocate may hand out
  localparam logic [CountW-1:0] FirstDataCluster = CountW'(2);
  localparam logic [CountW-1:0] TableCount       = CountW'(TableEntries);

  // command codes
  localparam logic [1:0] CmdRead  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdAlloc = 2'd2;
  localparam logic [1:0] CmdFree  = 2'd3;

  // status codes
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusRange = 2'd2;

  // configuration register indexes
  localparam logic CfgClusterCount = 1'b0;
  localparam logic CfgEndMarker    = 1'b1;

  // register reset values
  localparam logic [CountW-1:0] ClusterCountReset = CountW'(4096);
  localparam logic [DataW-1:0]  EndMarkerReset    = 32'h0FFF_FFF8;

endpackage : fcte_pkg

`default_nettype wire

// ===== design/fat_cluster_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_table_engine_unit
// Cluster allocation table in one single-port-write synchronous RAM with a
// read-modify-write sequencer for read, write, allocate and free chain.
// ----------------------------------------------------------------------------
// After reset the RAM is cleared one entry per cycle (all 4096 entries, busy high).
// Write and out-of-range commands: result one cycle after start. Read: the RAM
// read port output is registered, then the result. Allocate: entries are scanned from the
// lowest possibly free one (one RAM read per cycle, kept short by a low-water free hint).
// Free chain: the links are walked with one RAM read-modify-write per cycle.
// A new command is taken in the cycle the result strobe is high; the receiver cannot stall.
`default_nettype none

module fat_cluster_table_engine_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    command_i,
  input  wire logic [fcte_pkg::AddrW-1:0]    cluster_index_i,
  input  wire logic [fcte_pkg::DataW-1:0]    entry_value_i,
  // result strobe
  output logic                               result_valid_o,
  output logic [1:0]                         status_o,
  output logic [fcte_pkg::DataW-1:0]         result_value_o,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [fcte_pkg::DataW-1:0]    cfg_data_i
);

  import fcte_pkg::*;

  // sequencer states
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StAlloc = 3'd3;
  localparam logic [2:0] StFree  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [CountW-1:0] scan_q, scan_d;
  logic [AddrW-1:0]  cur_q, cur_d;
  logic [CountW-1:0] steps_q, steps_d;
  logic [CountW-1:0] hint_q, hint_d;
  logic [CountW-1:0] cnt_q;
  logic [DataW-1:0]  marker_q;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [DataW-1:0]  result_q, result_d;

  // ram ports
  logic [DataW-1:0]  ram_mem [TableEntries];
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [DataW-1:0]  ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [DataW-1:0]  ram_q;
  logic              fwd_q;
  logic [DataW-1:0]  fwd_data_q;
  logic [DataW-1:0]  rd_data;

  logic [CountW-1:0] limit;
  logic [CountW-1:0] scan_next;
  logic [CountW-1:0] steps_next;
  logic [DataW-1:0]  limit_ext;

  // effective entry count
  assign limit      = (cnt_q > TableCount) ? TableCount : cnt_q;
  assign limit_ext  = {{(DataW-CountW){1'b0}}, limit};
  assign scan_next  = scan_q + CountW'(1);
  assign steps_next = steps_q + CountW'(1);

  // table ram, write port
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
  end

  // table ram, registered read port with same-address forwarding
  always_ff @(posedge clk_i) begin
    ram_q      <= ram_mem[ram_raddr];
    fwd_q      <= ram_we && (ram_waddr == ram_raddr);
    fwd_data_q <= ram_wdata;
  end

  assign rd_data = fwd_q ? fwd_data_q : ram_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    hint_d      = hint_q;
    out_valid_d = 1'b0;
    status_d    = status_q;
    result_d    = result_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_q;
    ram_wdata   = '0;
    ram_raddr   = cluster_index_i;

    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == {AddrW{1'b1}}) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        if (start) begin
          if (command_i == CmdAlloc) begin
            if (hint_q >= limit) begin
              out_valid_d = 1'b1;
              status_d    = StatusFull;
              result_d    = '0;
            end else begin
              ram_raddr = hint_q[AddrW-1:0];
              scan_d    = hint_q;
              state_d   = StAlloc;
            end
          end else if ({1'b0, cluster_index_i} >= limit) begin
            out_valid_d = 1'b1;
            status_d    = StatusRange;
            result_d    = '0;
          end else begin
            unique case (command_i)
              CmdRead: begin
                state_d = StRead;
              end
              CmdWrite: begin
                ram_we      = 1'b1;
                ram_waddr   = cluster_index_i;
                ram_wdata   = entry_value_i;
                out_valid_d = 1'b1;
                status_d    = StatusOk;
                result_d    = '0;
                if (entry_value_i == '0 && {1'b0, cluster_index_i} >= FirstDataCluster
                    && {1'b0, cluster_index_i} < hint_q) begin
                  hint_d = {1'b0, cluster_index_i};
                end
              end
              default: begin
                // free chain: a start at or above the end marker is a no-op
                if ({{(DataW-AddrW){1'b0}}, cluster_index_i} >= marker_q) begin
                  out_valid_d = 1'b1;
                  status_d    = StatusOk;
                  result_d    = '0;
                end else begin
                  cur_d   = cluster_index_i;
                  steps_d = '0;
                  state_d = StFree;
                end
              end
            endcase
          end
        end
      end

      StRead: begin
        out_valid_d = 1'b1;
        status_d    = StatusOk;
        result_d    = rd_data;
        state_d     = StIdle;
      end

      StAlloc: begin
        // next entry is read ahead while this one is checked
        ram_raddr = scan_next[AddrW-1:0];
        if (rd_data == '0) begin
          ram_we      = 1'b1;
          ram_waddr   = scan_q[AddrW-1:0];
          ram_wdata   = marker_q;
          out_valid_d = 1'b1;
          status_d    = StatusOk;
          result_d    = {{(DataW-CountW){1'b0}}, scan_q};
          hint_d      = (marker_q != '0) ? scan_next : scan_q;
          state_d     = StIdle;
        end else if (scan_next >= limit) begin
          out_valid_d = 1'b1;
          status_d    = StatusFull;
          result_d    = '0;
          hint_d      = limit;
          state_d     = StIdle;
        end else begin
          scan_d = scan_next;
        end
      end

      StFree: begin
        // zero the current link and follow the old value
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = '0;
        ram_raddr = rd_data[AddrW-1:0];
        if ({1'b0, cur_q} >= FirstDataCluster && {1'b0, cur_q} < hint_q) begin
          hint_d = {1'b0, cur_q};
        end
        if (rd_data >= marker_q || rd_data == '0 || rd_data >= limit_ext
            || steps_next >= limit) begin
          out_valid_d = 1'b1;
          status_d    = StatusOk;
          result_d    = '0;
          state_d     = StIdle;
        end else begin
          cur_d   = rd_data[AddrW-1:0];
          steps_d = steps_next;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      hint_q      <= FirstDataCluster;
      out_valid_q <= 1'b0;
      cnt_q       <= ClusterCountReset;
      marker_q    <= EndMarkerReset;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgClusterCount: cnt_q    <= cfg_data_i[CountW-1:0];
          default:         marker_q <= cfg_data_i;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_q   <= scan_d;
    cur_q    <= cur_d;
    steps_q  <= steps_d;
    status_q <= status_d;
    result_q <= result_d;
  end

  assign busy           = (state_q != StIdle);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = result_q;

`ifndef SYNTHESIS
  // every accepted command either completes next cycle or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("command neither completed nor in progress");

  // free hint stays between the first data cluster and the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hint_q >= FirstDataCluster) && (hint_q <= TableCount))
    else $error("free hint out of bounds");

  // chain walk never exceeds the loop guard
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFree) |-> (steps_q < limit))
    else $error("chain walk passed its step limit");

  // a result only comes out while no walk or scan is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == StIdle))
    else $error("result strobe outside idle");
`endif

endmodule : fat_cluster_table_engine_unit

`default_nettype wire
